// File: sv/cse_pkg.sv
// ----------------------------------------------------------------------------
// Cosecant series evaluator package
// Shared widths, constants and the series coefficient table.
// ----------------------------------------------------------------------------
package cse_pkg;

    localparam int MAX_TERMS = 12;
    localparam int IDX_W     = 4;

    localparam logic [31:0] PI_LIMIT_Q29 = 32'd1686628289;
    localparam logic [63:0] MAG_MAX      = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [3:0]  TC_RESET     = 4'd12;
    localparam logic [31:0] THR_RESET    = 32'd43;

    localparam logic [3:0] CFG_TERM_COUNT = 4'd0;
    localparam logic [3:0] CFG_STOP_THR   = 4'd1;

    typedef logic [63:0] t_coef_tab [0:MAX_TERMS];

    // F_k = 16^k / (2k+1)! in Q16.48, each step truncated
    localparam logic [63:0] FACT_F0  = 64'd1 << 48;
    localparam logic [63:0] FACT_F1  = (FACT_F0  * 64'd16) / 64'd6;
    localparam logic [63:0] FACT_F2  = (FACT_F1  * 64'd16) / 64'd20;
    localparam logic [63:0] FACT_F3  = (FACT_F2  * 64'd16) / 64'd42;
    localparam logic [63:0] FACT_F4  = (FACT_F3  * 64'd16) / 64'd72;
    localparam logic [63:0] FACT_F5  = (FACT_F4  * 64'd16) / 64'd110;
    localparam logic [63:0] FACT_F6  = (FACT_F5  * 64'd16) / 64'd156;
    localparam logic [63:0] FACT_F7  = (FACT_F6  * 64'd16) / 64'd210;
    localparam logic [63:0] FACT_F8  = (FACT_F7  * 64'd16) / 64'd272;
    localparam logic [63:0] FACT_F9  = (FACT_F8  * 64'd16) / 64'd342;
    localparam logic [63:0] FACT_F10 = (FACT_F9  * 64'd16) / 64'd420;
    localparam logic [63:0] FACT_F11 = (FACT_F10 * 64'd16) / 64'd506;
    localparam logic [63:0] FACT_F12 = (FACT_F11 * 64'd16) / 64'd600;

    localparam t_coef_tab FACT_F = '{FACT_F0, FACT_F1, FACT_F2, FACT_F3, FACT_F4,
                                     FACT_F5, FACT_F6, FACT_F7, FACT_F8, FACT_F9,
                                     FACT_F10, FACT_F11, FACT_F12};

    // A_n = c_n * 16^n in Q16.48, built with the same truncations as the
    // Bernoulli recursion; evaluated at elaboration only.
    function automatic t_coef_tab build_coef();
        t_coef_tab    a;
        logic [127:0] prod;
        logic [63:0]  acc;
        logic [63:0]  pr;
        a[0] = 64'd1 << 48;
        for (int n = 1; n <= MAX_TERMS; n++) begin
            acc = '0;
            for (int k = 1; k <= n; k++) begin
                prod = {64'd0, a[n-k]} * {64'd0, FACT_F[k]};
                if ((prod >> 48) > {64'd0, {64{1'b1}}}) begin
                    pr = {64{1'b1}};
                end else begin
                    pr = prod[111:48];
                end
                if (k[0]) begin
                    acc = acc + pr;
                end else begin
                    acc = acc - pr;
                end
            end
            a[n] = acc;
        end
        return a;
    endfunction

    localparam t_coef_tab COEF_A = build_coef();

endpackage

// File: sv/cosecant_series_evaluator_top.sv
// Order from accepting edge to result valid: the reciprocal, x^2, a term product per
// term and a power update between terms, then the result load; a term below threshold
// ends the series, and a domain error skips divider and multiplier. Throughput: one
// request at a time, o_in_stall high until the result is loaded; the divider and the
// 4-pass multiplier set it.
// Reset (synchronous, active low): term_count 12, stop_threshold 43, block idle.
// ----------------------------------------------------------------------------
// Cosecant series evaluator
// Sequencer around a shared multiplier and a divider for csc(x) by series.
// ----------------------------------------------------------------------------
module cosecant_series_evaluator_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [31:0] i_x_value,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [63:0] o_csc_value,
    output logic [3:0]  o_terms_used,
    output logic        o_domain_error,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [3:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);
    import cse_pkg::*;

    typedef enum logic [2:0] {S_IDLE, S_DIV, S_SQR, S_TERM, S_POW, S_OUT} t_state;

    t_state      r_state;
    logic [3:0]  r_tc;
    logic [31:0] r_thr;
    logic        r_neg;
    logic        r_err;
    logic [31:0] r_mag;
    logic [3:0]  r_limit;
    logic [3:0]  r_i;
    logic [3:0]  r_used;
    logic [63:0] r_sum;
    logic [63:0] r_y2;
    logic [63:0] r_p;
    logic        r_out_valid;
    logic [63:0] r_csc;
    logic [3:0]  r_tu;
    logic        r_derr;

    logic         n_mul_start;
    logic [63:0]  n_mul_a, n_mul_b;
    logic         w_mul_done;
    logic [127:0] w_prod;
    logic         n_div_start;
    logic         w_div_done;
    logic [63:0]  w_quot;

    logic [31:0] w_mag;
    logic        w_dom_err;
    logic        w_accept;
    logic [45:0] w_term;
    logic [64:0] w_sum_ext;
    logic [63:0] w_sum_sat;
    logic        w_out_free;

    assign w_mag      = i_x_value[31] ? (32'd0 - i_x_value) : i_x_value;
    assign w_dom_err  = (w_mag == 32'd0) || (w_mag >= PI_LIMIT_Q29);
    assign w_accept   = i_in_valid && (r_state == S_IDLE);
    assign w_term     = w_prod[127:82];
    assign w_sum_ext  = {1'b0, r_sum} + {19'd0, w_term};
    assign w_sum_sat  = (w_sum_ext > {1'b0, MAG_MAX}) ? MAG_MAX : w_sum_ext[63:0];
    assign w_out_free = !r_out_valid || !i_out_stall;

    cse_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (n_mul_start),
        .i_a     (n_mul_a),
        .i_b     (n_mul_b),
        .o_done  (w_mul_done),
        .o_prod  (w_prod)
    );

    cse_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (n_div_start),
        .i_den   (w_mag),
        .o_done  (w_div_done),
        .o_quot  (w_quot)
    );

    always_comb begin
        n_mul_start = 1'b0;
        n_mul_a     = COEF_A[r_i];
        n_mul_b     = r_p;
        n_div_start = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                // start the reciprocal on the accepting edge
                if (w_accept && !w_dom_err) begin
                    n_div_start = 1'b1;
                end
            end
            S_DIV: begin
                if (w_div_done) begin
                    n_mul_start = 1'b1;
                    n_mul_a     = {r_mag, 32'd0} << 1;
                    n_mul_b     = {r_mag, 32'd0} << 1;
                end
            end
            S_SQR: begin
                if (w_mul_done && r_limit != 4'd0) begin
                    n_mul_start = 1'b1;
                    n_mul_a     = COEF_A[4'd1];
                    n_mul_b     = {r_mag, 32'd0} << 1;
                end
            end
            S_TERM: begin
                if (w_mul_done && !(w_term < {14'd0, r_thr}) && (r_used + 4'd1 != r_limit)) begin
                    n_mul_start = 1'b1;
                    n_mul_a     = r_p;
                    n_mul_b     = r_y2;
                end
            end
            S_POW: begin
                if (w_mul_done) begin
                    n_mul_start = 1'b1;
                    n_mul_a     = COEF_A[r_i + 4'd1];
                    n_mul_b     = w_prod[127:64];
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_tc        <= TC_RESET;
            r_thr       <= THR_RESET;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                if (i_cfg_index == CFG_TERM_COUNT) begin
                    r_tc <= i_cfg_data[3:0];
                end else if (i_cfg_index == CFG_STOP_THR) begin
                    r_thr <= i_cfg_data;
                end
            end

            if (r_state == S_OUT && w_out_free) begin
                r_out_valid <= 1'b1;
                r_csc       <= r_err ? 64'd0 : (r_neg ? (64'd0 - r_sum) : r_sum);
                r_tu        <= r_err ? 4'd0 : r_used;
                r_derr      <= r_err;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_neg   <= i_x_value[31];
                        r_mag   <= w_mag;
                        r_used  <= '0;
                        r_i     <= 4'd1;
                        r_limit <= (r_tc > 4'(MAX_TERMS)) ? 4'(MAX_TERMS) : r_tc;
                        if (w_dom_err) begin
                            r_err   <= 1'b1;
                            r_state <= S_OUT;
                        end else begin
                            r_err   <= 1'b0;
                            r_state <= S_DIV;
                        end
                    end
                end
                S_DIV: begin
                    if (w_div_done) begin
                        r_sum   <= w_quot;
                        r_state <= S_SQR;
                    end
                end
                S_SQR: begin
                    if (w_mul_done) begin
                        r_y2    <= w_prod[127:64];
                        r_p     <= {r_mag, 32'd0} << 1;
                        r_state <= (r_limit == 4'd0) ? S_OUT : S_TERM;
                    end
                end
                S_TERM: begin
                    if (w_mul_done) begin
                        // drop the term below threshold and stop
                        if (w_term < {14'd0, r_thr}) begin
                            r_state <= S_OUT;
                        end else begin
                            r_sum  <= w_sum_sat;
                            r_used <= r_used + 4'd1;
                            r_state <= (r_used + 4'd1 == r_limit) ? S_OUT : S_POW;
                        end
                    end
                end
                S_POW: begin
                    if (w_mul_done) begin
                        r_p     <= w_prod[127:64];
                        r_i     <= r_i + 4'd1;
                        r_state <= S_TERM;
                    end
                end
                S_OUT: begin
                    if (w_out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_stall     = (r_state != S_IDLE);
    assign o_cfg_ready    = 1'b1;
    assign o_out_valid    = r_out_valid;
    assign o_csc_value    = r_csc;
    assign o_terms_used   = r_tu;
    assign o_domain_error = r_derr;

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_domain_error) |-> (o_csc_value == 64'd0 && o_terms_used == 4'd0))
        else $error("domain error result not cleared");

    a_tu_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_terms_used <= 4'(MAX_TERMS)))
        else $error("terms_used out of range");

    a_used_lim: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_TERM || r_state == S_POW) |-> (r_used < r_limit))
        else $error("term counter past limit");

endmodule

// File: sv/cse_mul.sv
// ----------------------------------------------------------------------------
// Shared 64x64 multiplier
// Full 128-bit product from four 32x32 partial products, one per cycle.
// ----------------------------------------------------------------------------
module cse_mul (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_start,
    input  logic [63:0]  i_a,
    input  logic [63:0]  i_b,
    output logic         o_done,
    output logic [127:0] o_prod
);
    import cse_pkg::*;

    logic [63:0]  r_a, r_b;
    logic [2:0]   r_step;
    logic         r_busy;
    logic [63:0]  r_pp;
    logic [6:0]   r_sh;
    logic [127:0] r_acc;
    logic         r_done;

    logic [31:0] w_ah, w_bh;
    always_comb begin
        w_ah = r_step[1] ? r_a[63:32] : r_a[31:0];
        w_bh = r_step[0] ? r_b[63:32] : r_b[31:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_step <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_a    <= i_a;
                r_b    <= i_b;
                r_acc  <= '0;
                r_step <= '0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                if (r_step < 3'd4) begin
                    r_pp <= 64'(w_ah) * 64'(w_bh);
                    r_sh <= 7'({r_step[1], 5'd0}) + 7'({r_step[0], 5'd0});
                end
                // add the partial product from the previous step
                if (r_step != 3'd0) begin
                    r_acc <= r_acc + ({64'd0, r_pp} << r_sh);
                end
                if (r_step == 3'd4) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
                r_step <= r_step + 3'd1;
            end
        end
    end

    assign o_done = r_done;
    assign o_prod = r_acc;
endmodule

// File: sv/cse_div.sv
// ----------------------------------------------------------------------------
// Reciprocal divider
// Restoring division of 2^61 by a 31-bit magnitude, one quotient bit a cycle.
// ----------------------------------------------------------------------------
module cse_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [31:0] i_den,
    output logic        o_done,
    output logic [63:0] o_quot
);
    import cse_pkg::*;

    logic [31:0] r_den;
    logic [32:0] r_rem;
    logic [61:0] r_quot;
    logic [5:0]  r_bit;
    logic        r_busy;
    logic        r_done;

    logic [32:0] w_shift;
    logic [32:0] w_diff;
    always_comb begin
        // the numerator has a single one at bit 61
        w_shift = {r_rem[31:0], (r_bit == 6'd61)};
        w_diff  = w_shift - {1'b0, r_den};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_den  <= i_den;
                r_rem  <= '0;
                r_quot <= '0;
                r_bit  <= 6'd61;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                if (!w_diff[32]) begin
                    r_rem  <= w_diff;
                    r_quot <= {r_quot[60:0], 1'b1};
                end else begin
                    r_rem  <= w_shift;
                    r_quot <= {r_quot[60:0], 1'b0};
                end
                if (r_bit == 6'd0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
                r_bit <= r_bit - 6'd1;
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = {2'b00, r_quot};
endmodule
